>>> rtl/nec_ir_pkg.sv
// ----------------------------------------------------------------------------
// nec_ir_pkg
// Types and constants shared by the infrared frame decoder.
// ----------------------------------------------------------------------------
package nec_ir_pkg;

   // frame layout: one ignored duration, leader mark, leader space, 32 pairs
   localparam int unsigned FrameDurations = 1 + 2 + 2 * 32;
   localparam int unsigned PosWidth       = 7;
   localparam int unsigned DurWidth       = 8;
   localparam int unsigned PeriodWidth    = 9;
   localparam int unsigned WordWidth      = 32;
   localparam int unsigned CsrIndexWidth  = 4;

   localparam logic [PosWidth-1:0] POS_LEADER_MARK  = PosWidth'(1);
   localparam logic [PosWidth-1:0] POS_LEADER_SPACE = PosWidth'(2);
   localparam logic [PosWidth-1:0] POS_FIRST_PAIR   = PosWidth'(3);
   localparam logic [PosWidth-1:0] POS_FRAME_DONE   = PosWidth'(FrameDurations);

   localparam logic [7:0] BYTE_ALL_ONES = 8'hff;

   // register reset values
   localparam logic [DurWidth-1:0]    LEADER_MARK_MIN_RST  = 8'd162;
   localparam logic [DurWidth-1:0]    LEADER_MARK_MAX_RST  = 8'd198;
   localparam logic [DurWidth-1:0]    LEADER_SPACE_MIN_RST = 8'd81;
   localparam logic [DurWidth-1:0]    LEADER_SPACE_MAX_RST = 8'd99;
   localparam logic [PeriodWidth-1:0] ZERO_PERIOD_MIN_RST  = 9'd20;
   localparam logic [PeriodWidth-1:0] ZERO_PERIOD_MAX_RST  = 9'd25;
   localparam logic [PeriodWidth-1:0] ONE_PERIOD_MIN_RST   = 9'd40;
   localparam logic [PeriodWidth-1:0] ONE_PERIOD_MAX_RST   = 9'd50;

   // register indexes
   localparam logic [CsrIndexWidth-1:0] CSR_LEADER_MARK_MIN  = 4'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_LEADER_MARK_MAX  = 4'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_LEADER_SPACE_MIN = 4'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_LEADER_SPACE_MAX = 4'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_ZERO_PERIOD_MIN  = 4'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_ZERO_PERIOD_MAX  = 4'd5;
   localparam logic [CsrIndexWidth-1:0] CSR_ONE_PERIOD_MIN   = 4'd6;
   localparam logic [CsrIndexWidth-1:0] CSR_ONE_PERIOD_MAX   = 4'd7;

   typedef struct packed {
      logic [DurWidth-1:0] duration;
      logic                frame_end;
   } req_type;

   typedef struct packed {
      logic       frame_ok;
      logic [7:0] address_high;
      logic [7:0] address_low;
      logic [7:0] command_byte;
   } rsp_type;

endpackage

>>> rtl/nec_ir_frame_decoder.sv
// ----------------------------------------------------------------------------
// nec_ir_frame_decoder
// Decodes one infrared remote frame from a stream of pulse and gap durations
// and reports address, command and a pass flag at the frame's last duration.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake             beat
//   req_*     in         req_valid/req_stall   one duration, frame end flag
//   rsp_*     out        rsp_valid/rsp_stall   one decoded frame result
//   csr_*     in         csr_valid/csr_ready   register index and write data
//
// One duration is taken per cycle unless req_stall is high; window checks
// and the pair sum sit between the frame state registers and a two-entry
// result queue, whose head or skid slot registers each frame-ending result.
// req_stall rises only while both result slots are full.
// Synchronous reset restores register defaults and starts a new frame.
// csr_ready is always high.
//
module nec_ir_frame_decoder (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  nec_ir_pkg::req_type                      req_data,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output nec_ir_pkg::rsp_type                      rsp_data,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [nec_ir_pkg::CsrIndexWidth-1:0]     csr_index,
   input  logic [nec_ir_pkg::PeriodWidth-1:0]       csr_wdata
);

   // configuration registers
   logic [nec_ir_pkg::DurWidth-1:0]    leader_mark_min_ff, leader_mark_max_ff;
   logic [nec_ir_pkg::DurWidth-1:0]    leader_space_min_ff, leader_space_max_ff;
   logic [nec_ir_pkg::PeriodWidth-1:0] zero_period_min_ff, zero_period_max_ff;
   logic [nec_ir_pkg::PeriodWidth-1:0] one_period_min_ff, one_period_max_ff;

   // frame state
   logic [nec_ir_pkg::PosWidth-1:0]    position_count_ff, position_count_in;
   logic [nec_ir_pkg::DurWidth-1:0]    held_mark_ff, held_mark_in;
   logic [nec_ir_pkg::WordWidth-1:0]   bit_shift_ff, bit_shift_in;
   logic                               frame_failed_ff, frame_failed_in;

   // result queue: head drives the port, skid catches a result under stall
   logic                               head_valid_ff, head_valid_in;
   nec_ir_pkg::rsp_type                head_ff, head_in;
   logic                               skid_valid_ff, skid_valid_in;
   nec_ir_pkg::rsp_type                skid_ff, skid_in;

   logic                               req_accept;
   logic                               rsp_pop;
   logic                               rsp_push;
   logic [nec_ir_pkg::PeriodWidth-1:0] pair_sum;
   logic                               in_zero, in_one;
   logic                               word_ok;
   nec_ir_pkg::rsp_type                result;

   assign csr_ready  = 1'b1;
   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = head_valid_ff;
   assign rsp_data   = head_ff;
   assign rsp_pop    = head_valid_ff && !rsp_stall;
   assign rsp_push   = req_accept && req_data.frame_end;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         leader_mark_min_ff  <= nec_ir_pkg::LEADER_MARK_MIN_RST;
         leader_mark_max_ff  <= nec_ir_pkg::LEADER_MARK_MAX_RST;
         leader_space_min_ff <= nec_ir_pkg::LEADER_SPACE_MIN_RST;
         leader_space_max_ff <= nec_ir_pkg::LEADER_SPACE_MAX_RST;
         zero_period_min_ff  <= nec_ir_pkg::ZERO_PERIOD_MIN_RST;
         zero_period_max_ff  <= nec_ir_pkg::ZERO_PERIOD_MAX_RST;
         one_period_min_ff   <= nec_ir_pkg::ONE_PERIOD_MIN_RST;
         one_period_max_ff   <= nec_ir_pkg::ONE_PERIOD_MAX_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            nec_ir_pkg::CSR_LEADER_MARK_MIN:
               leader_mark_min_ff <= csr_wdata[nec_ir_pkg::DurWidth-1:0];
            nec_ir_pkg::CSR_LEADER_MARK_MAX:
               leader_mark_max_ff <= csr_wdata[nec_ir_pkg::DurWidth-1:0];
            nec_ir_pkg::CSR_LEADER_SPACE_MIN:
               leader_space_min_ff <= csr_wdata[nec_ir_pkg::DurWidth-1:0];
            nec_ir_pkg::CSR_LEADER_SPACE_MAX:
               leader_space_max_ff <= csr_wdata[nec_ir_pkg::DurWidth-1:0];
            nec_ir_pkg::CSR_ZERO_PERIOD_MIN: zero_period_min_ff <= csr_wdata;
            nec_ir_pkg::CSR_ZERO_PERIOD_MAX: zero_period_max_ff <= csr_wdata;
            nec_ir_pkg::CSR_ONE_PERIOD_MIN:  one_period_min_ff  <= csr_wdata;
            nec_ir_pkg::CSR_ONE_PERIOD_MAX:  one_period_max_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // pair sum and period windows
   assign pair_sum = {1'b0, held_mark_ff} + {1'b0, req_data.duration};
   assign in_zero  = (pair_sum >= zero_period_min_ff) && (pair_sum <= zero_period_max_ff);
   assign in_one   = (pair_sum >= one_period_min_ff) && (pair_sum <= one_period_max_ff);

   // frame state update for one duration
   always_comb begin
      position_count_in = position_count_ff;
      held_mark_in      = held_mark_ff;
      bit_shift_in      = bit_shift_ff;
      frame_failed_in   = frame_failed_ff;
      if (position_count_ff == nec_ir_pkg::POS_LEADER_MARK) begin
         if (req_data.duration < leader_mark_min_ff
             || req_data.duration > leader_mark_max_ff) begin
            frame_failed_in = 1'b1;
         end
      end else if (position_count_ff == nec_ir_pkg::POS_LEADER_SPACE) begin
         if (req_data.duration < leader_space_min_ff
             || req_data.duration > leader_space_max_ff) begin
            frame_failed_in = 1'b1;
         end
      end else if (position_count_ff >= nec_ir_pkg::POS_FIRST_PAIR
                   && position_count_ff < nec_ir_pkg::POS_FRAME_DONE) begin
         // pairs start at an odd position: odd holds the mark, even decodes
         if (position_count_ff[0]) begin
            held_mark_in = req_data.duration;
         end else begin
            bit_shift_in = {bit_shift_ff[nec_ir_pkg::WordWidth-2:0], !in_zero && in_one};
            if (!in_zero && !in_one) begin
               frame_failed_in = 1'b1;
            end
         end
      end
      if (position_count_ff < nec_ir_pkg::POS_FRAME_DONE) begin
         position_count_in = position_count_ff + nec_ir_pkg::PosWidth'(1);
      end
   end

   // result for a frame ending on this beat
   assign word_ok = !frame_failed_in
                    && position_count_in >= nec_ir_pkg::POS_FRAME_DONE
                    && ((bit_shift_in[15:8] ^ bit_shift_in[7:0]) == nec_ir_pkg::BYTE_ALL_ONES);

   always_comb begin
      result.frame_ok     = word_ok;
      result.address_high = word_ok ? bit_shift_in[31:24] : 8'd0;
      result.address_low  = word_ok ? bit_shift_in[23:16] : 8'd0;
      result.command_byte = word_ok ? bit_shift_in[15:8]  : 8'd0;
   end

   // frame state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         position_count_ff <= '0;
         held_mark_ff      <= '0;
         bit_shift_ff      <= '0;
         frame_failed_ff   <= 1'b0;
      end else if (req_accept) begin
         if (req_data.frame_end) begin
            position_count_ff <= '0;
            held_mark_ff      <= '0;
            bit_shift_ff      <= '0;
            frame_failed_ff   <= 1'b0;
         end else begin
            position_count_ff <= position_count_in;
            held_mark_ff      <= held_mark_in;
            bit_shift_ff      <= bit_shift_in;
            frame_failed_ff   <= frame_failed_in;
         end
      end
   end

   // result queue next state
   always_comb begin
      head_valid_in = head_valid_ff;
      head_in       = head_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (rsp_pop) begin
         if (skid_valid_ff) begin
            head_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            head_valid_in = rsp_push;
            head_in       = result;
         end
      end else if (rsp_push) begin
         if (head_valid_ff) begin
            skid_valid_in = 1'b1;
            skid_in       = result;
         end else begin
            head_valid_in = 1'b1;
            head_in       = result;
         end
      end
   end

   // result queue control
   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // result queue payload
   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

endmodule
